[hw/rtl/fsde_pkg.sv]
// Shared types and constants for the frame store draw engine.
// Used by fsde_store, fsde_ctrl and frame_store_draw_engine_unit; depends on nothing.
package fsde_pkg;

    localparam int COORD_W = 12;
    localparam int COLOR_W = 32;
    localparam int COUNT_W = 13;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 13'd8191;

    // configuration register indexes
    localparam logic CFG_WIDE_PIXELS = 1'b0;
    localparam logic CFG_OPAQUE_MODE = 1'b1;

    typedef enum logic [2:0]
    {
        REQ_PLOT  = 3'd0,
        REQ_HLINE = 3'd1,
        REQ_VLINE = 3'd2,
        REQ_RECT  = 3'd3,
        REQ_CLEAR = 3'd4,
        REQ_READ  = 3'd5
    } req_t;

    typedef struct packed
    {
        req_t                      req;
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic signed [COORD_W-1:0] x2;
        logic signed [COORD_W-1:0] y2;
        logic [COLOR_W-1:0]        color;
    } cmd_t;

    typedef struct packed
    {
        logic wide;
        logic opaque;
    } mode_t;

    typedef struct packed
    {
        logic [COLOR_W-1:0] read_data;
        logic [COUNT_W-1:0] pixels_written;
    } res_t;

endpackage

[hw/rtl/frame_store_draw_engine_unit.sv]
// Top level of the frame store draw engine: stream ports, mode registers, result register.
// Depends on fsde_pkg, fsde_store and fsde_ctrl.

// Draws into a FRAME_WIDTH x FRAME_HEIGHT store of 32-bit pixels (address y*FRAME_WIDTH+x)
// and returns one result item per command. One command is in work at a time and s_tready
// is low meanwhile. Every drawn pixel is a read-modify-write through the single RAM port:
// a read state, then a write state, after a base state for setup and before a done state
// for hand-over; a fully clipped command goes straight to the done state. Clear sweeps the
// whole store at one word a cycle. After reset the same sweep runs once before the first
// item is taken; configuration writes are taken at any time. A finished result waits in
// the output register while the next item is taken.
module frame_store_draw_engine_unit
#(
    parameter int FRAME_WIDTH  = 64,
    parameter int FRAME_HEIGHT = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // coord_x1[11:0], coord_y1[23:12], coord_x2[35:24], coord_y2[47:36], pen_color[79:48]
    input  logic [79:0] s_tdata,
    // req_type[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_data[31:0], pixels_written[44:32], zero[47:45]
    output logic [47:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic        cfg_data
);
    import fsde_pkg::*;

    localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    mode_t              mode_reg;
    logic               m_tvalid_reg;
    res_t               res_reg;
    cmd_t               cmd;
    res_t               res;
    logic               ctrl_ready, done, res_ready;
    logic               mem_we, mem_re;
    logic [AW-1:0]      mem_addr;
    logic [COLOR_W-1:0] mem_wdata, mem_rdata;

    assign cmd.req   = req_t'(s_tuser);
    assign cmd.x1    = s_tdata[11:0];
    assign cmd.y1    = s_tdata[23:12];
    assign cmd.x2    = s_tdata[35:24];
    assign cmd.y2    = s_tdata[47:36];
    assign cmd.color = s_tdata[79:48];

    assign s_tready  = ctrl_ready;
    assign cfg_ready = 1'b1;
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg.wide   <= 1'b1;
            mode_reg.opaque <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_WIDE_PIXELS: mode_reg.wide   <= cfg_data;
                CFG_OPAQUE_MODE: mode_reg.opaque <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (done)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, res_reg.pixels_written, res_reg.read_data};

    fsde_ctrl
    #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT),
        .AW           (AW)
    )
    u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (s_tvalid && ctrl_ready),
        .cmd       (cmd),
        .mode      (mode_reg),
        .res_ready (res_ready),
        .ready     (ctrl_ready),
        .done      (done),
        .res       (res),
        .mem_we    (mem_we),
        .mem_re    (mem_re),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

    fsde_store
    #(
        .DEPTH (DEPTH),
        .AW    (AW)
    )
    u_store
    (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

endmodule

[hw/rtl/fsde_store.sv]
// Pixel frame store: single-port RAM, one access per cycle, registered read data.
// Depends on fsde_pkg for the word width.
module fsde_store
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
)
(
    input  logic                    clk,
    input  logic                    we,
    input  logic                    re,
    input  logic [AW-1:0]           addr,
    input  logic [fsde_pkg::COLOR_W-1:0] wdata,
    output logic [fsde_pkg::COLOR_W-1:0] rdata
);
    import fsde_pkg::*;

    logic [COLOR_W-1:0] mem [DEPTH];
    logic [COLOR_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/fsde_ctrl.sv]
// Command sequencer: clips each command, walks its pixels one read-modify-write at a time
// through the frame store, sweeps the store on clear and after reset. Depends on fsde_pkg.
module fsde_ctrl
#(
    parameter int FRAME_WIDTH  = 64,
    parameter int FRAME_HEIGHT = 64,
    parameter int AW           = 12
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  fsde_pkg::cmd_t               cmd,
    input  fsde_pkg::mode_t              mode,
    input  logic                         res_ready,
    output logic                         ready,
    output logic                         done,
    output fsde_pkg::res_t               res,
    output logic                         mem_we,
    output logic                         mem_re,
    output logic [AW-1:0]                mem_addr,
    output logic [fsde_pkg::COLOR_W-1:0] mem_wdata,
    input  logic [fsde_pkg::COLOR_W-1:0] mem_rdata
);
    import fsde_pkg::*;

    localparam int XW    = $clog2(FRAME_WIDTH);
    localparam int YW    = $clog2(FRAME_HEIGHT);
    localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
    localparam logic signed [COORD_W:0] XMAX = (COORD_W+1)'(FRAME_WIDTH - 1);
    localparam logic signed [COORD_W:0] YMAX = (COORD_W+1)'(FRAME_HEIGHT - 1);

    typedef enum logic [3:0]
    {
        ST_INIT,
        ST_IDLE,
        ST_BASE,
        ST_RD,
        ST_WR,
        ST_PIXRD,
        ST_PIXWAIT,
        ST_CLEAR,
        ST_DONE
    } state_t;

    state_t             state_reg, state_next;
    req_t               req_reg, req_next;
    logic [XW-1:0]      xa_reg, xa_next, xb_reg, xb_next, x_reg, x_next;
    logic [YW-1:0]      ya_reg, ya_next, yb_reg, yb_next, y_reg, y_next;
    logic [AW-1:0]      row_reg, row_next, addr_reg, addr_next;
    logic [COLOR_W-1:0] color_reg, color_next, data_reg, data_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic signed [COORD_W:0] x1e, y1e, x2e, y2e;
    logic signed [COORD_W:0] x_lo, x_hi, y_lo, y_hi;
    logic signed [COORD_W:0] xa_c, xb_c, ya_c, yb_c;
    logic                    empty;
    logic [AW-1:0]           base_addr;
    logic [COLOR_W-1:0]      merged;
    logic [COUNT_W-1:0]      count_inc;

    assign x1e = {cmd.x1[COORD_W-1], cmd.x1};
    assign y1e = {cmd.y1[COORD_W-1], cmd.y1};
    assign x2e = {cmd.x2[COORD_W-1], cmd.x2};
    assign y2e = {cmd.y2[COORD_W-1], cmd.y2};

    // span bounds before clipping; lines order their endpoints
    always_comb
    begin
        x_lo = x1e;
        x_hi = x1e;
        y_lo = y1e;
        y_hi = y1e;
        case (cmd.req)
            REQ_HLINE:
            begin
                x_lo = (x1e <= x2e) ? x1e : x2e;
                x_hi = (x1e <= x2e) ? x2e : x1e;
            end
            REQ_VLINE:
            begin
                y_lo = (y1e <= y2e) ? y1e : y2e;
                y_hi = (y1e <= y2e) ? y2e : y1e;
            end
            REQ_RECT:
            begin
                x_hi = x2e;
                y_hi = y2e;
            end
            default:
            begin
            end
        endcase
    end

    // a reversed rectangle also comes out empty here
    assign xa_c  = (x_lo < 0) ? '0 : x_lo;
    assign ya_c  = (y_lo < 0) ? '0 : y_lo;
    assign xb_c  = (x_hi > XMAX) ? XMAX : x_hi;
    assign yb_c  = (y_hi > YMAX) ? YMAX : y_hi;
    assign empty = (xa_c > xb_c) || (ya_c > yb_c);

    assign base_addr = AW'(ya_reg) * AW'(FRAME_WIDTH) + AW'(xa_reg);
    assign count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;

    always_comb
    begin
        if (mode.wide)
        begin
            merged = mode.opaque ? color_reg : (mem_rdata | color_reg);
        end
        else
        begin
            merged = {mem_rdata[31:16],
                      mode.opaque ? color_reg[15:0] : (mem_rdata[15:0] | color_reg[15:0])};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        xa_next    = xa_reg;
        xb_next    = xb_reg;
        ya_next    = ya_reg;
        yb_next    = yb_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        row_next   = row_reg;
        addr_next  = addr_reg;
        color_next = color_reg;
        data_next  = data_reg;
        count_next = count_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_wdata  = merged;
        done       = 1'b0;

        case (state_reg)
            ST_INIT:
            begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next   = cmd.req;
                    color_next = cmd.color;
                    count_next = '0;
                    data_next  = '0;
                    addr_next  = '0;
                    xa_next    = xa_c[XW-1:0];
                    xb_next    = xb_c[XW-1:0];
                    ya_next    = ya_c[YW-1:0];
                    yb_next    = yb_c[YW-1:0];
                    case (cmd.req)
                        REQ_PLOT, REQ_HLINE, REQ_VLINE, REQ_RECT, REQ_READ:
                        begin
                            state_next = empty ? ST_DONE : ST_BASE;
                        end
                        REQ_CLEAR:
                        begin
                            state_next = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_BASE:
            begin
                row_next   = base_addr;
                addr_next  = base_addr;
                x_next     = xa_reg;
                y_next     = ya_reg;
                state_next = (req_reg == REQ_READ) ? ST_PIXRD : ST_RD;
            end
            ST_RD:
            begin
                mem_re     = 1'b1;
                state_next = ST_WR;
            end
            ST_WR:
            begin
                mem_we     = 1'b1;
                count_next = count_inc;
                state_next = ST_RD;
                if (x_reg == xb_reg)
                begin
                    if (y_reg == yb_reg)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        y_next    = y_reg + 1'b1;
                        x_next    = xa_reg;
                        row_next  = row_reg + AW'(FRAME_WIDTH);
                        addr_next = row_reg + AW'(FRAME_WIDTH);
                    end
                end
                else
                begin
                    x_next    = x_reg + 1'b1;
                    addr_next = addr_reg + 1'b1;
                end
            end
            ST_PIXRD:
            begin
                mem_re     = 1'b1;
                state_next = ST_PIXWAIT;
            end
            ST_PIXWAIT:
            begin
                data_next  = mode.wide ? mem_rdata : {16'h0000, mem_rdata[15:0]};
                state_next = ST_DONE;
            end
            ST_CLEAR:
            begin
                mem_we     = 1'b1;
                mem_wdata  = '0;
                count_next = count_inc;
                addr_next  = addr_reg + 1'b1;
                if (addr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    done       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            addr_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        xa_reg    <= xa_next;
        xb_reg    <= xb_next;
        ya_reg    <= ya_next;
        yb_reg    <= yb_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        row_reg   <= row_next;
        color_reg <= color_next;
        data_reg  <= data_next;
        count_reg <= count_next;
    end

    assign ready              = (state_reg == ST_IDLE);
    assign mem_addr           = addr_reg;
    assign res.read_data      = data_reg;
    assign res.pixels_written = count_reg;

endmodule
